### sv/h2oc_pkg.sv
// Shared types, widths and constants of the water-vapour concentration pipeline.
`timescale 1ns / 1ps
`default_nettype none
package h2oc_pkg;

  localparam int P_W    = 16;
  localparam int T_W    = 16;
  localparam int S_W    = 24;
  localparam int CONC_W = 32;
  localparam int REF_W  = 17;
  localparam int COEF_W = 64;
  localparam int IDX_W  = 2;

  localparam int Q1_W   = 48;
  localparam int K5_W   = 19;
  localparam int D_W    = 20;
  localparam int MA_W   = 224;
  localparam int MB_W   = 48;
  localparam int MP_W   = 256;
  localparam int V_W    = MP_W - 56;
  localparam int DIV_STEPS = 4;

  localparam logic [S_W-1:0]   PRESS_SCALE = 24'd16208000;
  localparam logic [REF_W-1:0] REF_RESET   = 17'd80550;
  localparam logic signed [COEF_W-1:0] C0_RESET = 64'sd2008380253826;
  localparam logic signed [COEF_W-1:0] C1_RESET = 64'sd1026933305;
  localparam logic signed [COEF_W-1:0] C2_RESET = -64'sd10796;

  localparam logic [IDX_W-1:0] CFG_REF_TEMP  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_COEF_LIN  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_COEF_SQ   = 2'd2;
  localparam logic [IDX_W-1:0] CFG_COEF_CUBE = 2'd3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO_P = 2'd1,
    ST_SAT    = 2'd2
  } status_t;

  typedef struct packed {
    logic              pz;
    logic              sneg;
    logic              rneg;
    logic              ovf;
    logic [P_W-1:0]    p;
    logic [K5_W-1:0]   k5;
    logic [Q1_W-1:0]   xs;
  } side_t;

  localparam int NST    = 40;
  localparam int D1_LO  = 1;
  localparam int D1_HI  = 13;
  localparam int S_XS   = 14;
  localparam int S_M1   = 15;
  localparam int S_H1   = 18;
  localparam int S_M2   = 19;
  localparam int S_H0   = 22;
  localparam int S_M3   = 23;
  localparam int S_MAG  = 26;
  localparam int S_M4   = 27;
  localparam int S_V    = 30;
  localparam int D2_LO  = 31;
  localparam int D2_HI  = 39;
  localparam int S_OUT  = 40;

endpackage
`default_nettype wire

### sv/h2oc_wmul.sv
// Three-stage signed multiplier of a wide operand by a 48-bit operand.
`timescale 1ns / 1ps
`default_nettype none
module h2oc_wmul (
  input  wire logic                              clk,
  input  wire logic [2:0]                        adv,
  input  wire logic signed [h2oc_pkg::MA_W-1:0]  mul_a,
  input  wire logic signed [h2oc_pkg::MB_W-1:0]  mul_b,
  output logic signed [h2oc_pkg::MP_W-1:0]       mul_p
);

  localparam int NCH = h2oc_pkg::MA_W / 32;
  localparam int HB  = h2oc_pkg::MB_W / 2;
  localparam int PPW = 33 + HB + 1;

  logic signed [32:0]     ach [NCH];
  logic signed [HB:0]     blo;
  logic signed [HB:0]     bhi;
  logic signed [PPW-1:0]  pplo_nxt [NCH];
  logic signed [PPW-1:0]  pphi_nxt [NCH];
  logic signed [PPW-1:0]  pplo_r [NCH];
  logic signed [PPW-1:0]  pphi_r [NCH];
  logic signed [h2oc_pkg::MP_W-1:0] lo_nxt, hi_nxt, lo_r, hi_r, p_r;

  always_comb begin
    blo = $signed({1'b0, mul_b[HB-1:0]});
    bhi = $signed({mul_b[h2oc_pkg::MB_W-1], mul_b[h2oc_pkg::MB_W-1:HB]});
    for (int i = 0; i < NCH; i++) begin
      if (i == NCH - 1) begin
        ach[i] = $signed({mul_a[32*i+31], mul_a[32*i +: 32]});
      end else begin
        ach[i] = $signed({1'b0, mul_a[32*i +: 32]});
      end
      pplo_nxt[i] = PPW'(ach[i]) * PPW'(blo);
      pphi_nxt[i] = PPW'(ach[i]) * PPW'(bhi);
    end
  end

  always_comb begin
    lo_nxt = '0;
    hi_nxt = '0;
    for (int i = 0; i < NCH; i++) begin
      lo_nxt = lo_nxt + (h2oc_pkg::MP_W'(pplo_r[i]) <<< (32 * i));
      hi_nxt = hi_nxt + (h2oc_pkg::MP_W'(pphi_r[i]) <<< (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < NCH; i++) begin
        pplo_r[i] <= pplo_nxt[i];
        pphi_r[i] <= pphi_nxt[i];
      end
    end
    if (adv[1]) begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
    if (adv[2]) begin
      p_r <= lo_r + (hi_r <<< HB);
    end
  end

  assign mul_p = p_r;

endmodule
`default_nettype wire

### sv/h2o_analyzer_concentration.sv
// Top level of the pipelined water-vapour concentration calculator.
//
// Requests arrive on the in_ channel (valid/ready) carrying cell pressure,
// cell temperature and the raw water-vapour signal; each request yields
// exactly one result on the out_ channel with the concentration and a status.
// The pipeline is 40 register stages deep, and one request is accepted every
// cycle while the receiver keeps up. The depth is set by the 48-step
// pressure divider and the 32-step rounding divider, each retiring four
// quotient bits per stage, and by four three-stage multipliers for the
// cubic and temperature. Each stage advances when its successor is empty or
// moving, so a stalled receiver holds the finished result while empty stages
// still take requests. Configuration registers are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while no request
// is in flight, which the block itself does not enforce. A synchronous
// active-low reset empties the pipeline and restores the calibration
// registers to their defaults. Zero pressure gives status 1 with a zero
// result; a result outside the signed 32-bit range saturates with status 2.
`timescale 1ns / 1ps
`default_nettype none
module h2o_analyzer_concentration (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [h2oc_pkg::P_W-1:0]            in_pressure_mb,
  input  wire logic signed [h2oc_pkg::T_W-1:0]     in_cell_temp_c,
  input  wire logic signed [h2oc_pkg::S_W-1:0]     in_h2o_signal,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [h2oc_pkg::CONC_W-1:0]       out_h2o_conc,
  output logic [1:0]                               out_status,
  input  wire logic                                cfg_we,
  input  wire logic [h2oc_pkg::IDX_W-1:0]          cfg_index,
  input  wire logic [h2oc_pkg::COEF_W-1:0]         cfg_wdata
);

  localparam int NST  = h2oc_pkg::NST;
  localparam int P_W  = h2oc_pkg::P_W;
  localparam int Q1_W = h2oc_pkg::Q1_W;
  localparam int D_W  = h2oc_pkg::D_W;
  localparam int MA_W = h2oc_pkg::MA_W;
  localparam int MB_W = h2oc_pkg::MB_W;
  localparam int MP_W = h2oc_pkg::MP_W;
  localparam int V_W  = h2oc_pkg::V_W;
  localparam int CW   = h2oc_pkg::CONC_W;
  localparam int K5_W = h2oc_pkg::K5_W;

  logic [h2oc_pkg::REF_W-1:0]          ref_temp_k_r;
  logic signed [h2oc_pkg::COEF_W-1:0]  coef_linear_r, coef_square_r, coef_cube_r;
  logic [D_W-1:0]                      d_r;

  logic [NST:1]            vld_r;
  logic [NST:1]            vld_nxt;
  logic [NST:1]            en;
  h2oc_pkg::side_t         side_r   [1:NST];
  h2oc_pkg::side_t         side_nxt [1:NST];

  logic [P_W-1:0]          d1_rem_r   [h2oc_pkg::D1_LO:h2oc_pkg::D1_HI];
  logic [Q1_W-1:0]         d1_num_r   [h2oc_pkg::D1_LO:h2oc_pkg::D1_HI];
  logic [P_W-1:0]          d1_rem_nxt [h2oc_pkg::D1_LO:h2oc_pkg::D1_HI];
  logic [Q1_W-1:0]         d1_num_nxt [h2oc_pkg::D1_LO:h2oc_pkg::D1_HI];
  logic [D_W-1:0]          d2_rem_r   [h2oc_pkg::D2_LO:h2oc_pkg::D2_HI];
  logic [CW-1:0]           d2_num_r   [h2oc_pkg::D2_LO:h2oc_pkg::D2_HI];
  logic [D_W-1:0]          d2_rem_nxt [h2oc_pkg::D2_LO:h2oc_pkg::D2_HI];
  logic [CW-1:0]           d2_num_nxt [h2oc_pkg::D2_LO:h2oc_pkg::D2_HI];

  logic [h2oc_pkg::S_W-1:0]  smag;
  logic signed [20:0]        k5_full;
  logic signed [MA_W-1:0]    h1_nxt, h1_r, h0_nxt, h0_r, mag_r;
  logic signed [MP_W-1:0]    m1_p, m2_p, m3_p, m4_p, nabs;
  logic [MP_W-1:0]           vsum;
  logic [V_W-1:0]            v_r;
  logic [CW-1:0]             q_fin, conc_nxt, conc_r;
  h2oc_pkg::status_t         status_nxt, status_r;
  logic                      over;

  function automatic logic [P_W+Q1_W-1:0] div1_stage(input logic [P_W-1:0] rem_i,
                                                      input logic [Q1_W-1:0] num_i,
                                                      input logic [P_W-1:0] dv);
    logic [P_W:0]    t;
    logic [P_W-1:0]  rem;
    logic [Q1_W-1:0] num;
    rem = rem_i;
    num = num_i;
    for (int i = 0; i < h2oc_pkg::DIV_STEPS; i++) begin
      t   = {rem, num[Q1_W-1]};
      num = {num[Q1_W-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t      = t - {1'b0, dv};
        num[0] = 1'b1;
      end
      rem = t[P_W-1:0];
    end
    return {rem, num};
  endfunction

  function automatic logic [D_W+CW-1:0] div2_stage(input logic [D_W-1:0] rem_i,
                                                    input logic [CW-1:0] num_i,
                                                    input logic [D_W-1:0] dv);
    logic [D_W:0]   t;
    logic [D_W-1:0] rem;
    logic [CW-1:0]  num;
    rem = rem_i;
    num = num_i;
    for (int i = 0; i < h2oc_pkg::DIV_STEPS; i++) begin
      t   = {rem, num[CW-1]};
      num = {num[CW-2:0], 1'b0};
      if (t >= {1'b0, dv}) begin
        t      = t - {1'b0, dv};
        num[0] = 1'b1;
      end
      rem = t[D_W-1:0];
    end
    return {rem, num};
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_temp_k_r  <= h2oc_pkg::REF_RESET;
      coef_linear_r <= h2oc_pkg::C0_RESET;
      coef_square_r <= h2oc_pkg::C1_RESET;
      coef_cube_r   <= h2oc_pkg::C2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        h2oc_pkg::CFG_REF_TEMP:  ref_temp_k_r  <= cfg_wdata[h2oc_pkg::REF_W-1:0];
        h2oc_pkg::CFG_COEF_LIN:  coef_linear_r <= cfg_wdata;
        h2oc_pkg::CFG_COEF_SQ:   coef_square_r <= cfg_wdata;
        h2oc_pkg::CFG_COEF_CUBE: coef_cube_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    d_r <= D_W'((ref_temp_k_r == '0) ? 1 : ref_temp_k_r) * D_W'(5);
  end

  always_comb begin
    en[NST] = !vld_r[NST] || out_ready;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt = {vld_r[NST-1:1], in_valid};
  end

  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NST; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  always_comb begin
    smag    = in_h2o_signal[h2oc_pkg::S_W-1] ? -in_h2o_signal : in_h2o_signal;
    k5_full = 21'(in_cell_temp_c) * 21'sd5 + 21'sd349632;

    side_nxt[1].pz   = (in_pressure_mb == '0);
    side_nxt[1].sneg = in_h2o_signal[h2oc_pkg::S_W-1];
    side_nxt[1].rneg = 1'b0;
    side_nxt[1].ovf  = 1'b0;
    side_nxt[1].p    = in_pressure_mb;
    side_nxt[1].k5   = k5_full[K5_W-1:0];
    side_nxt[1].xs   = '0;
    for (int k = 2; k <= NST; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    side_nxt[h2oc_pkg::S_XS].xs = side_r[h2oc_pkg::S_XS-1].sneg ?
                                  -d1_num_r[h2oc_pkg::D1_HI] : d1_num_r[h2oc_pkg::D1_HI];
    side_nxt[h2oc_pkg::S_MAG].rneg = m3_p[MP_W-1];
    side_nxt[h2oc_pkg::D2_LO].ovf  = (v_r[V_W-1:CW] >= (V_W-CW)'(d_r));

    d1_rem_nxt[h2oc_pkg::D1_LO] = '0;
    d1_num_nxt[h2oc_pkg::D1_LO] = smag * h2oc_pkg::PRESS_SCALE;
    for (int k = h2oc_pkg::D1_LO + 1; k <= h2oc_pkg::D1_HI; k++) begin
      {d1_rem_nxt[k], d1_num_nxt[k]} = div1_stage(d1_rem_r[k-1], d1_num_r[k-1],
                                                   side_r[k-1].p);
    end

    h1_nxt = (MA_W'(coef_square_r) <<< 8) + $signed(m1_p[MA_W-1:0]);
    h0_nxt = (MA_W'(coef_linear_r) <<< 16) + $signed(m2_p[MA_W-1:0]);
    nabs   = m3_p[MP_W-1] ? -m3_p : m3_p;
    vsum   = $unsigned(m4_p) + (MP_W'(d_r) << 55);

    d2_rem_nxt[h2oc_pkg::D2_LO] = v_r[CW +: D_W];
    d2_num_nxt[h2oc_pkg::D2_LO] = v_r[CW-1:0];
    for (int k = h2oc_pkg::D2_LO + 1; k <= h2oc_pkg::D2_HI; k++) begin
      {d2_rem_nxt[k], d2_num_nxt[k]} = div2_stage(d2_rem_r[k-1], d2_num_r[k-1], d_r);
    end

    q_fin = d2_num_r[h2oc_pkg::D2_HI];
    over  = side_r[h2oc_pkg::D2_HI].ovf ||
            (q_fin > (side_r[h2oc_pkg::D2_HI].rneg ? 32'h8000_0000 : 32'h7fff_ffff));
    if (side_r[h2oc_pkg::D2_HI].pz) begin
      conc_nxt   = '0;
      status_nxt = h2oc_pkg::ST_ZERO_P;
    end else if (over) begin
      conc_nxt   = side_r[h2oc_pkg::D2_HI].rneg ? 32'h8000_0000 : 32'h7fff_ffff;
      status_nxt = h2oc_pkg::ST_SAT;
    end else begin
      conc_nxt   = side_r[h2oc_pkg::D2_HI].rneg ? -q_fin : q_fin;
      status_nxt = h2oc_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NST; k++) begin
      if (en[k]) begin
        side_r[k] <= side_nxt[k];
      end
    end
    for (int k = h2oc_pkg::D1_LO; k <= h2oc_pkg::D1_HI; k++) begin
      if (en[k]) begin
        d1_rem_r[k] <= d1_rem_nxt[k];
        d1_num_r[k] <= d1_num_nxt[k];
      end
    end
    for (int k = h2oc_pkg::D2_LO; k <= h2oc_pkg::D2_HI; k++) begin
      if (en[k]) begin
        d2_rem_r[k] <= d2_rem_nxt[k];
        d2_num_r[k] <= d2_num_nxt[k];
      end
    end
    if (en[h2oc_pkg::S_H1]) begin
      h1_r <= h1_nxt;
    end
    if (en[h2oc_pkg::S_H0]) begin
      h0_r <= h0_nxt;
    end
    if (en[h2oc_pkg::S_MAG]) begin
      mag_r <= nabs[MA_W-1:0];
    end
    if (en[h2oc_pkg::S_V]) begin
      v_r <= vsum[MP_W-1:56];
    end
    if (en[h2oc_pkg::S_OUT]) begin
      conc_r   <= conc_nxt;
      status_r <= status_nxt;
    end
  end

  h2oc_wmul u_mul_c2 (
    .clk   (clk),
    .adv   (en[h2oc_pkg::S_M1+2:h2oc_pkg::S_M1]),
    .mul_a (MA_W'(coef_cube_r)),
    .mul_b ($signed(side_r[h2oc_pkg::S_XS].xs)),
    .mul_p (m1_p)
  );

  h2oc_wmul u_mul_h1 (
    .clk   (clk),
    .adv   (en[h2oc_pkg::S_M2+2:h2oc_pkg::S_M2]),
    .mul_a (h1_r),
    .mul_b ($signed(side_r[h2oc_pkg::S_H1].xs)),
    .mul_p (m2_p)
  );

  h2oc_wmul u_mul_h0 (
    .clk   (clk),
    .adv   (en[h2oc_pkg::S_M3+2:h2oc_pkg::S_M3]),
    .mul_a (h0_r),
    .mul_b ($signed(side_r[h2oc_pkg::S_H0].xs)),
    .mul_p (m3_p)
  );

  h2oc_wmul u_mul_k5 (
    .clk   (clk),
    .adv   (en[h2oc_pkg::S_M4+2:h2oc_pkg::S_M4]),
    .mul_a (mag_r),
    .mul_b ($signed({{(MB_W-K5_W){1'b0}}, side_r[h2oc_pkg::S_MAG].k5})),
    .mul_p (m4_p)
  );

  assign out_valid    = vld_r[NST];
  assign out_h2o_conc = conc_r;
  assign out_status   = status_r;

endmodule
`default_nettype wire

### sv/h2oc_checker.sv
// Port-level checks of the concentration block and their binding to it.
`timescale 1ns / 1ps
`default_nettype none
module h2oc_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [h2oc_pkg::CONC_W-1:0]  out_h2o_conc,
  input wire logic [1:0]                          out_status
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_h2o_conc) && $stable(out_status))
    else $error("result changed while stalled");

  a_zero_p: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == h2oc_pkg::ST_ZERO_P |-> out_h2o_conc == '0)
    else $error("zero pressure result is not zero");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == h2oc_pkg::ST_SAT |->
      out_h2o_conc == 32'sh7fff_ffff || out_h2o_conc == 32'sh8000_0000)
    else $error("saturated result is not a range limit");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind h2o_analyzer_concentration h2oc_checker u_h2oc_checker (.*);
`default_nettype wire
